// File: src/gatf_pkg.sv
// Package for the gray frame engine with anti-transpose readout.
// Holds sizes, gray weights, register and command codes, and the command word.
// No dependencies.
package gatf_pkg;

  localparam int MAX_SIDE     = 256;
  localparam int FRAME_PIXELS = 65536;
  localparam int QUEUE_DEPTH  = 2;

  localparam int PIX_W   = 8;
  localparam int SIDE_W  = $clog2(MAX_SIDE);
  localparam int DIM_W   = SIDE_W + 1;
  localparam int ADDR_W  = $clog2(FRAME_PIXELS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int IDX_W   = 2 * DIM_W;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = PIX_W + FRAC_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [FRAC_W-1:0] WEIGHT_R = FRAC_W'(19661);
  localparam logic [FRAC_W-1:0] WEIGHT_G = FRAC_W'(38666);
  localparam logic [FRAC_W-1:0] WEIGHT_B = FRAC_W'(7209);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_SIDE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COLOR  = 2'd2
  } cfg_idx_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_NOTREADY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             color;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  gray;
    logic              mem_ok;
    logic              last;
  } cmd_t;

endpackage

// File: src/gatf_pix_if.sv
// Pixel input channel: valid, ready and one pixel word.
// Depends on gatf_pkg for field widths.
interface gatf_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [gatf_pkg::PIX_W-1:0] red;
  logic [gatf_pkg::PIX_W-1:0] green;
  logic [gatf_pkg::PIX_W-1:0] blue;

  modport source (output valid, output opcode, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input opcode, input red, input green, input blue,
                  output ready);
endinterface

// File: src/gatf_res_if.sv
// Result output channel: valid, ready and one result word.
// Depends on gatf_pkg for field widths.
interface gatf_res_if;
  logic                      valid;
  logic                      ready;
  logic [gatf_pkg::PIX_W-1:0] gray;
  logic                      ready_res;
  logic                      last;

  modport source (output valid, output gray, output ready_res, output last, input ready);
  modport sink   (input valid, input gray, input ready_res, input last, output ready);
endinterface

// File: src/gatf_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
// Depends on gatf_pkg for field widths.
interface gatf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gatf_pkg::CFG_IDX_W-1:0]  index;
  logic [gatf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/gatf_front.sv
// Front end: accepts pixel words, reduces pixels to gray, tracks load and readout
// position, and issues store commands. Depends on gatf_pkg and gatf_pix_if.
module gatf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gatf_pkg::cfg_t  cfg_i,
  gatf_pix_if.sink        pix_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output gatf_pkg::cmd_t  cmd_o
);

  localparam logic [gatf_pkg::CNT_W-1:0] CNT_LIM = gatf_pkg::CNT_W'(gatf_pkg::FRAME_PIXELS);
  localparam logic [gatf_pkg::IDX_W-1:0] IDX_LIM = gatf_pkg::IDX_W'(gatf_pkg::FRAME_PIXELS);

  logic [gatf_pkg::CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [gatf_pkg::SIDE_W-1:0] row_q, row_d;
  logic [gatf_pkg::SIDE_W-1:0] col_q, col_d;
  logic                        full_q, full_d;

  logic                        accept;
  logic [gatf_pkg::IDX_W-1:0]  total;
  logic [gatf_pkg::CNT_W-1:0]  cnt_inc;
  logic [gatf_pkg::DIM_W-1:0]  r9, c9, r_nx, c_nx, src_row, src_col;
  logic [gatf_pkg::IDX_W-1:0]  idx;
  logic                        in_frame, is_last;
  logic [gatf_pkg::SUM_W-1:0]  wsum;
  logic [gatf_pkg::PIX_W-1:0]  gray;

  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = cmd_ready_i;

  assign total   = gatf_pkg::IDX_W'(cfg_i.width) * gatf_pkg::IDX_W'(cfg_i.height);
  assign cnt_inc = load_cnt_q + gatf_pkg::CNT_W'(1);

  assign r9   = {1'b0, row_q};
  assign c9   = {1'b0, col_q};
  assign r_nx = r9 + gatf_pkg::DIM_W'(1);
  assign c_nx = c9 + gatf_pkg::DIM_W'(1);
  assign src_row = cfg_i.height - gatf_pkg::DIM_W'(1) - c9;
  assign src_col = cfg_i.width - gatf_pkg::DIM_W'(1) - r9;
  assign idx = gatf_pkg::IDX_W'(src_row) * gatf_pkg::IDX_W'(cfg_i.width)
             + gatf_pkg::IDX_W'(src_col);
  assign in_frame = (r9 < cfg_i.width) && (c9 < cfg_i.height);
  assign is_last  = (c_nx >= cfg_i.height) && (r_nx >= cfg_i.width);

  assign wsum = gatf_pkg::SUM_W'(pix_i.red) * gatf_pkg::SUM_W'(gatf_pkg::WEIGHT_R)
              + gatf_pkg::SUM_W'(pix_i.green) * gatf_pkg::SUM_W'(gatf_pkg::WEIGHT_G)
              + gatf_pkg::SUM_W'(pix_i.blue) * gatf_pkg::SUM_W'(gatf_pkg::WEIGHT_B);
  assign gray = cfg_i.color ? wsum[gatf_pkg::FRAC_W +: gatf_pkg::PIX_W] : pix_i.red;

  always_comb begin
    load_cnt_d  = load_cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    full_d      = full_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind   = gatf_pkg::CMD_NOTREADY;
    cmd_o.addr   = load_cnt_q[gatf_pkg::ADDR_W-1:0];
    cmd_o.gray   = gray;
    cmd_o.mem_ok = 1'b0;
    cmd_o.last   = 1'b0;
    if (accept) begin
      if (pix_i.opcode == gatf_pkg::OP_LOAD) begin
        if (!full_q) begin
          cmd_valid_o = load_cnt_q < CNT_LIM;
          cmd_o.kind  = gatf_pkg::CMD_WRITE;
          load_cnt_d  = cnt_inc;
          if (gatf_pkg::IDX_W'(cnt_inc) >= total) begin
            full_d = 1'b1;
            row_d  = '0;
            col_d  = '0;
          end
        end
      end else begin
        cmd_valid_o = 1'b1;
        if (full_q) begin
          cmd_o.kind   = gatf_pkg::CMD_READ;
          cmd_o.addr   = idx[gatf_pkg::ADDR_W-1:0];
          cmd_o.mem_ok = in_frame && (idx < IDX_LIM);
          cmd_o.last   = is_last;
          if (is_last) begin
            full_d     = 1'b0;
            load_cnt_d = '0;
            row_d      = '0;
            col_d      = '0;
          end else if (c_nx >= cfg_i.height) begin
            col_d = '0;
            row_d = r_nx[gatf_pkg::SIDE_W-1:0];
          end else begin
            col_d = c_nx[gatf_pkg::SIDE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      full_q     <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      full_q     <= full_d;
    end
  end

endmodule

// File: src/gatf_queue.sv
// Short command queue between front and back end.
// Depends on gatf_pkg for the command word and depth.
module gatf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gatf_pkg::cmd_t in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gatf_pkg::cmd_t out_cmd_o
);

  localparam int PTR_W = (gatf_pkg::QUEUE_DEPTH > 1) ? $clog2(gatf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(gatf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(gatf_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(gatf_pkg::QUEUE_DEPTH);

  gatf_pkg::cmd_t   slot_q [gatf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_MAX;
  assign out_valid_o = count_q != '0;
  assign out_cmd_o   = slot_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/gatf_back.sv
// Back end: carries out store commands on the frame memory and drives results.
// Depends on gatf_pkg and gatf_res_if.
module gatf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  gatf_pkg::cmd_t cmd_i,
  gatf_res_if.source     res_o
);

  logic [gatf_pkg::PIX_W-1:0] mem [gatf_pkg::FRAME_PIXELS];
  logic [gatf_pkg::PIX_W-1:0] rd_q;
  logic out_valid_q, out_valid_d;
  logic use_mem_q, use_mem_d;
  logic ready_res_q, ready_res_d;
  logic last_q, last_d;
  logic pop, is_read;

  assign cmd_ready_o = !out_valid_q || res_o.ready;
  assign pop     = cmd_valid_i && cmd_ready_o;
  assign is_read = cmd_i.kind == gatf_pkg::CMD_READ;

  assign res_o.valid     = out_valid_q;
  assign res_o.gray      = use_mem_q ? rd_q : '0;
  assign res_o.ready_res = ready_res_q;
  assign res_o.last      = last_q;

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.kind == gatf_pkg::CMD_WRITE) begin
      mem[cmd_i.addr] <= cmd_i.gray;
    end
    if (pop && is_read && cmd_i.mem_ok) begin
      rd_q <= mem[cmd_i.addr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    use_mem_d   = use_mem_q;
    ready_res_d = ready_res_q;
    last_d      = last_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop && cmd_i.kind != gatf_pkg::CMD_WRITE) begin
      out_valid_d = 1'b1;
      use_mem_d   = is_read && cmd_i.mem_ok;
      ready_res_d = is_read;
      last_d      = is_read && cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      use_mem_q   <= 1'b0;
      ready_res_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      use_mem_q   <= use_mem_d;
      ready_res_q <= ready_res_d;
      last_q      <= last_d;
    end
  end

endmodule

// File: src/grayscale_anti_transpose_frame.sv
// Gray frame engine with anti-transpose readout: top level, configuration registers.
// Depends on gatf_pkg, the channel interfaces, gatf_front, gatf_queue, gatf_back.
//
// Load words (opcode 0) fill one frame in raster order, each pixel reduced to a gray
// byte; read words (opcode 1) return the frame mirrored about its anti-diagonal, one
// result per read, the final pixel flagged by last, then the engine loads again. A
// read before the frame is full returns a zero result with ready_res low. The block
// takes one word per clock unless results stall; gray byte and store address are
// combinational, a two-word queue follows, and the back end makes one access to
// the single-port frame memory per word; a result passes the queue, then an output
// register. The frame memory is not cleared after reset. The user writes the width,
// height and color registers only while the engine is idle; it is not enforced.
module grayscale_anti_transpose_frame (
  input  logic       clk_i,
  input  logic       rst_ni,
  gatf_cfg_if.sink   cfg_i,
  gatf_pix_if.sink   pix_i,
  gatf_res_if.source res_o
);

  logic [gatf_pkg::DIM_W-1:0] width_q, width_d;
  logic [gatf_pkg::DIM_W-1:0] height_q, height_d;
  logic                       color_q, color_d;
  gatf_pkg::cfg_t             cfg_eff;

  logic           f_valid, f_ready, b_valid, b_ready;
  gatf_pkg::cmd_t f_cmd, b_cmd;

  function automatic logic [gatf_pkg::DIM_W-1:0] clamp_side(logic [gatf_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return gatf_pkg::DIM_W'(1);
    end else if (v > gatf_pkg::DIM_RESET) begin
      return gatf_pkg::DIM_RESET;
    end
    return v;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    color_d  = color_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        gatf_pkg::CFG_WIDTH:  width_d  = cfg_i.data;
        gatf_pkg::CFG_HEIGHT: height_d = cfg_i.data;
        gatf_pkg::CFG_COLOR:  color_d  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gatf_pkg::DIM_RESET;
      height_q <= gatf_pkg::DIM_RESET;
      color_q  <= 1'b1;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      color_q  <= color_d;
    end
  end

  assign cfg_eff.width  = clamp_side(width_q);
  assign cfg_eff.height = clamp_side(height_q);
  assign cfg_eff.color  = color_q;

  gatf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_eff),
    .pix_i       (pix_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  gatf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_cmd_o   (b_cmd)
  );

  gatf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .res_o       (res_o)
  );

endmodule

// File: bench/grayscale_anti_transpose_frame_test.sv
// Testbench for grayscale_anti_transpose_frame: gray conversion, frame loads, anti-transpose readout.
// Depends on gatf_pkg and the gatf_cfg_if, gatf_pix_if and gatf_res_if channel interfaces.
// An in-bench frame predictor builds the expected words; each result word is checked in order.
`timescale 1ns / 100ps

module grayscale_anti_transpose_frame_test;
  import gatf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WT_RED        = 19661;
  localparam int unsigned WT_GREEN      = 38666;
  localparam int unsigned WT_BLUE       = 7209;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             ready_res;
    logic             last;
  } pixel_result_t;

  logic clk_i;
  logic rst_ni;

  gatf_cfg_if cfg_bus ();
  gatf_pix_if pix_bus ();
  gatf_res_if res_bus ();

  grayscale_anti_transpose_frame u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_bus),
    .res_o  (res_bus)
  );

  pixel_result_t    gray_expect_q[$];
  logic [PIX_W-1:0] frame_mem [FRAME_PIXELS];
  int unsigned      fill_pos;
  int unsigned      rd_row;
  int unsigned      rd_col;
  bit               frame_done;
  logic [DIM_W-1:0] reg_width;
  logic [DIM_W-1:0] reg_height;
  logic             reg_color;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned n_loads;
  int unsigned n_reads;
  int unsigned n_ignored;
  int unsigned n_frames;
  int unsigned n_reg_writes;
  int unsigned n_checked;
  int unsigned n_errors;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        n_checked++;
        if (gray_expect_q.size() == 0) begin
          n_errors++;
          $error("result word with nothing expected: gray %0d ready_res %0d last %0d",
                 res_bus.gray, res_bus.ready_res, res_bus.last);
        end else begin
          want = gray_expect_q.pop_front();
          if (res_bus.gray !== want.gray) begin
            n_errors++;
            $error("gray: expected %0d, got %0d", want.gray, res_bus.gray);
          end
          if (res_bus.ready_res !== want.ready_res) begin
            n_errors++;
            $error("ready_res: expected %0d, got %0d", want.ready_res, res_bus.ready_res);
          end
          if (res_bus.last !== want.last) begin
            n_errors++;
            $error("last: expected %0d, got %0d", want.last, res_bus.last);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int unsigned side_of(logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DIM_RESET) return MAX_SIDE;
    return 32'(raw);
  endfunction

  function automatic logic [PIX_W-1:0] gray_of(pixel_word_t w);
    int unsigned mix;
    if (!reg_color) return w.red;
    mix = 32'(w.red) * WT_RED + 32'(w.green) * WT_GREEN + 32'(w.blue) * WT_BLUE;
    return PIX_W'(mix >> 16);
  endfunction

  function automatic void predict_word(pixel_word_t w);
    int unsigned   wd;
    int unsigned   ht;
    int unsigned   idx;
    pixel_result_t outcome;
    wd = side_of(reg_width);
    ht = side_of(reg_height);
    if (w.opcode == OP_LOAD) begin
      if (frame_done) begin
        n_ignored++;
        return;
      end
      n_loads++;
      if (fill_pos < FRAME_PIXELS) frame_mem[fill_pos[ADDR_W-1:0]] = gray_of(w);
      fill_pos++;
      if (fill_pos >= wd * ht) begin
        frame_done = 1'b1;
        rd_row     = 0;
        rd_col     = 0;
      end
      return;
    end
    n_reads++;
    outcome = '0;
    if (frame_done) begin
      outcome.ready_res = 1'b1;
      if (rd_row < wd && rd_col < ht) begin
        idx = (ht - 1 - rd_col) * wd + (wd - 1 - rd_row);
        if (idx < FRAME_PIXELS) outcome.gray = frame_mem[idx[ADDR_W-1:0]];
      end
      outcome.last = (rd_col + 1 >= ht) && (rd_row + 1 >= wd);
      if (outcome.last) begin
        frame_done = 1'b0;
        fill_pos   = 0;
        rd_row     = 0;
        rd_col     = 0;
        n_frames++;
      end else begin
        rd_col++;
        if (rd_col >= ht) begin
          rd_col = 0;
          rd_row++;
        end
      end
    end
    gray_expect_q.push_back(outcome);
  endfunction

  function automatic pixel_word_t word_of(logic op, logic [PIX_W-1:0] r,
                                          logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    pixel_word_t w;
    w.opcode = op;
    w.red    = r;
    w.green  = g;
    w.blue   = b;
    return w;
  endfunction

  function automatic logic [PIX_W-1:0] random_byte();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic pixel_word_t random_word(logic op);
    return word_of(op, random_byte(), random_byte(), random_byte());
  endfunction

  task automatic send_word(pixel_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid  <= 1'b1;
    pix_bus.opcode <= w.opcode;
    pix_bus.red    <= w.red;
    pix_bus.green  <= w.green;
    pix_bus.blue   <= w.blue;
    do @(posedge clk_i); while (!pix_bus.ready);
    predict_word(w);
  endtask

  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (gray_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_WIDTH:  reg_width  = value;
      CFG_HEIGHT: reg_height = value;
      CFG_COLOR:  reg_color  = value[0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic write_regs(logic [DIM_W-1:0] wd, logic [DIM_W-1:0] hd, logic color);
    logic [CFG_DATA_W-1:0] color_word;
    color_word    = CFG_DATA_W'($urandom);
    color_word[0] = color;
    settle();
    write_reg(CFG_WIDTH, wd);
    write_reg(CFG_HEIGHT, hd);
    write_reg(CFG_COLOR, color_word);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_frame(int unsigned noise_pct, int unsigned max_words);
    int unsigned k;
    k = 0;
    while (!frame_done && k < max_words) begin
      if ($urandom_range(99) < noise_pct) send_word(random_word(OP_READ));
      send_word(random_word(OP_LOAD));
      k++;
    end
  endtask

  task automatic read_frame(int unsigned noise_pct, int unsigned max_words);
    int unsigned k;
    k = 0;
    while (frame_done && k < max_words) begin
      if ($urandom_range(99) < noise_pct) send_word(random_word(OP_LOAD));
      send_word(random_word(OP_READ));
      k++;
    end
  endtask

  // Keep a mid-readout shrink inside the pixels loaded for this frame.
  task automatic reshape_random();
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] hd;
    int unsigned      cap;
    int unsigned      sel;
    cap = frame_done ? fill_pos : FRAME_PIXELS;
    sel = $urandom_range(99);
    if (sel < 70) begin
      wd = DIM_W'($urandom_range(1, 6));
      hd = DIM_W'($urandom_range(1, 6));
    end else if (sel < 88) begin
      wd = DIM_W'($urandom_range(1, 16));
      hd = DIM_W'($urandom_range(1, 16));
    end else if (sel < 98) begin
      wd = $urandom_range(1) ? '0 : DIM_W'($urandom_range(1, 8));
      hd = $urandom_range(1) ? '0 : DIM_W'($urandom_range(1, 8));
    end else if ($urandom_range(1)) begin
      wd = DIM_W'($urandom_range(MAX_SIDE, 511));
      hd = DIM_W'(1);
    end else begin
      wd = DIM_W'(1);
      hd = DIM_W'($urandom_range(MAX_SIDE, 511));
    end
    if (side_of(wd) * side_of(hd) > cap) begin
      wd = DIM_W'(1);
      hd = DIM_W'((cap < MAX_SIDE) ? cap : MAX_SIDE);
    end
    write_regs(wd, hd, 1'($urandom_range(1)));
  endtask

  task automatic test_read_before_load();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(random_word(OP_READ));
    send_word(word_of(OP_READ, '1, '1, '1));
  endtask

  task automatic test_gray_weights();
    write_regs(3, 2, 1'b1);
    send_word(word_of(OP_LOAD, '1, '1, '1));
    send_word(word_of(OP_READ, '0, '0, '0));
    send_word(word_of(OP_LOAD, '0, '0, '0));
    send_word(word_of(OP_LOAD, '1, '0, '0));
    send_word(word_of(OP_LOAD, '0, '1, '0));
    send_word(word_of(OP_LOAD, '0, '0, '1));
    send_word(word_of(OP_LOAD, 8'h80, 8'h40, 8'h20));
    send_word(word_of(OP_LOAD, '1, '1, '1));
    read_frame(0, FRAME_PIXELS);
  endtask

  task automatic test_gray_passthrough();
    write_regs('0, 3, 1'b0);
    send_word(word_of(OP_LOAD, '0, '1, '1));
    send_word(word_of(OP_LOAD, '1, '0, '0));
    send_word(word_of(OP_LOAD, 8'hA5, 8'h5A, 8'hC3));
    read_frame(0, FRAME_PIXELS);
  endtask

  task automatic test_extreme_sides();
    write_regs(511, 1, 1'b1);
    load_frame(0, FRAME_PIXELS);
    read_frame(0, FRAME_PIXELS);
    write_regs(1, DIM_RESET, 1'b0);
    load_frame(0, FRAME_PIXELS);
    read_frame(0, FRAME_PIXELS);
  endtask

  task automatic test_resize_midframe();
    write_regs(4, 4, 1'b1);
    load_frame(0, 10);
    write_regs(3, 3, 1'b0);
    load_frame(0, FRAME_PIXELS);
    read_frame(0, 2);
    write_regs(2, 2, 1'b1);
    read_frame(0, FRAME_PIXELS);
    write_regs(2, 2, 1'b1);
    load_frame(0, 2);
    write_regs(3, 2, 1'b0);
    load_frame(0, FRAME_PIXELS);
    read_frame(0, FRAME_PIXELS);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_regs(6, 4, 1'b1);
    load_frame(0, FRAME_PIXELS);
    hold_left = 60;
    read_frame(10, FRAME_PIXELS);
    settle();
  endtask

  task automatic test_random_frames(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned budget);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = n_loads + n_reads + budget;
    while (n_loads + n_reads < stop_at) begin
      if ($urandom_range(99) < 60) reshape_random();
      if ($urandom_range(9) == 0) load_frame(5, $urandom_range(1, 20));
      else load_frame(5, FRAME_PIXELS);
      if ($urandom_range(9) == 0) read_frame(5, $urandom_range(1, 20));
      else read_frame(5, FRAME_PIXELS);
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    pix_bus.valid  = 1'b0;
    pix_bus.opcode = OP_LOAD;
    pix_bus.red    = '0;
    pix_bus.green  = '0;
    pix_bus.blue   = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_WIDTH;
    cfg_bus.data   = '0;
    res_bus.ready  = 1'b0;
    reg_width      = DIM_RESET;
    reg_height     = DIM_RESET;
    reg_color      = 1'b1;
    frame_done     = 1'b0;
    fill_pos       = 0;
    rd_row         = 0;
    rd_col         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycle_count    = 0;
    n_loads        = 0;
    n_reads        = 0;
    n_ignored      = 0;
    n_frames       = 0;
    n_reg_writes   = 0;
    n_checked      = 0;
    n_errors       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_read_before_load();
    test_gray_weights();
    test_gray_passthrough();
    test_resize_midframe();
    test_extreme_sides();
    test_backpressure();
    test_random_frames(0, 0, 170);
    test_random_frames(52, 0, 170);
    test_random_frames(0, 52, 170);
    test_random_frames(13, 13, 170);
    settle();

    $display("Checked %0d result words over %0d frames: %0d loads, %0d reads, %0d loads dropped.",
             n_checked, n_frames, n_loads, n_reads, n_ignored);
    $display("Made %0d register writes: sides 1 to 256, clamped sizes, RGB and gray input.",
             n_reg_writes);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gatf_pkg.sv
src/gatf_pix_if.sv
src/gatf_res_if.sv
src/gatf_cfg_if.sv
src/gatf_front.sv
src/gatf_queue.sv
src/gatf_back.sv
src/grayscale_anti_transpose_frame.sv
bench/grayscale_anti_transpose_frame_test.sv
